>>> rtl/core/sliding_window_variance_core_macros.svh
`ifndef SLIDING_WINDOW_VARIANCE_CORE_MACROS_SVH
`define SLIDING_WINDOW_VARIANCE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SWV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SWV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/swv_pkg.sv
`default_nettype none

package swv_pkg;

    localparam int WINDOW      = 24;
    localparam int SAMPLE_BITS = 10;
    localparam int VAR_BITS    = 19;

    localparam int POS_W = $clog2(WINDOW);

    localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned SUM_MAX    = longint'(WINDOW) * SAMPLE_MAX;
    localparam longint unsigned SQ_MAX     = longint'(WINDOW) * SAMPLE_MAX * SAMPLE_MAX;
    localparam longint unsigned NUM_MAX    = longint'(WINDOW) * SQ_MAX;

    localparam int SUM_W = $clog2(SUM_MAX + 64'd1);
    localparam int SQ_W  = $clog2(SQ_MAX + 64'd1);
    localparam int NUM_W = $clog2(NUM_MAX + 64'd1);

    localparam longint unsigned DEN   = longint'(WINDOW) * longint'(WINDOW - 1);
    localparam int              DEN_W = $clog2(DEN + 64'd1);

    localparam int              RECIP_SHIFT = NUM_W + DEN_W;
    localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / DEN;
    localparam int              RECIP_W     = $clog2(RECIP + 64'd1);
    localparam int              PROD_W      = NUM_W + RECIP_W;
    localparam int              QUO_W       = PROD_W - RECIP_SHIFT;

    localparam longint unsigned VAR_MAX = (64'd1 << VAR_BITS) - 64'd1;

    localparam int S_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((VAR_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SQ_W-1:0]  sq_total;
        logic [SUM_W-1:0] sum_total;
    } totals_t;

endpackage

`default_nettype wire

>>> rtl/core/sliding_window_variance_core.sv
// channel   dir  tdata                      tuser  tlast
// s_axis    in   [9:0] sample, rest zero    -      -
// m_axis    out  [18:0] variance, rest zero -      -
//
// One item per cycle unless the output stalls; a result goes via queue and pipeline.
// The divide by WINDOW*(WINDOW-1) is a reciprocal multiply with a one-step fix-up,
// over a three-stage pipeline behind the output register.
// rst_n clears the sample store, write pointer and totals at once; no clearing pass.
// A stalled result freezes the pipeline; a two-entry queue then takes items until full.
`default_nettype none

module sliding_window_variance_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swv_pkg::S_DATA_W-1:0]  s_tdata,   // [9:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swv_pkg::M_DATA_W-1:0]  m_tdata    // [18:0] variance
);
    import swv_pkg::*;

    logic                 push_valid;
    logic                 push_ready;
    totals_t              push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    totals_t              pop_data;
    logic [VAR_BITS-1:0]  variance;

    assign s_tready = push_ready;
    assign m_tdata  = M_DATA_W'(variance);

    swv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    swv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    swv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pop_valid),
        .in_ready     (pop_ready),
        .in_data      (pop_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_variance (variance)
    );

endmodule

`default_nettype wire

>>> rtl/core/swv_queue.sv
`default_nettype none

module swv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  swv_pkg::totals_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output swv_pkg::totals_t pop_data
);
    import swv_pkg::*;

    totals_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/swv_front.sv
`default_nettype none

module swv_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [swv_pkg::SAMPLE_BITS-1:0] in_sample,
    input  logic                          push_ready,
    output logic                          push_valid,
    output swv_pkg::totals_t              push_data
);
    import swv_pkg::*;

    logic [SAMPLE_BITS-1:0]   store_reg [WINDOW];
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_next;
    logic [SAMPLE_BITS-1:0]   stale;
    logic [2*SAMPLE_BITS-1:0] fresh_sq;
    logic [2*SAMPLE_BITS-1:0] stale_sq;
    logic                     accept;

    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;
    assign stale      = store_reg[pos_reg];
    assign fresh_sq   = in_sample * in_sample;
    assign stale_sq   = stale * stale;

    always_comb
    begin
        pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        sum_next = sum_reg + SUM_W'(in_sample) - SUM_W'(stale);
        sq_next  = sq_reg + SQ_W'(fresh_sq) - SQ_W'(stale_sq);
    end

    assign push_data.sum_total = sum_next;
    assign push_data.sq_total  = sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                store_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (accept)
        begin
            store_reg[pos_reg] <= in_sample;
            pos_reg            <= pos_next;
            sum_reg            <= sum_next;
            sq_reg             <= sq_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/swv_back.sv
`default_nettype none

module swv_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  swv_pkg::totals_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [swv_pkg::VAR_BITS-1:0] out_variance
);
    import swv_pkg::*;

    logic                 advance;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 out_valid_reg;
    logic [NUM_W-1:0]     num1_reg;
    logic [NUM_W-1:0]     num1_next;
    logic [NUM_W-1:0]     num2_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic [PROD_W-1:0]    prod2_next;
    logic [QUO_W-1:0]     quo3_reg;
    logic [QUO_W-1:0]     quo3_next;
    logic                 fix3_reg;
    logic                 fix3_next;
    logic [NUM_W-1:0]     rem3;
    logic [QUO_W:0]       quo_fixed;
    logic [VAR_BITS-1:0]  var_reg;
    logic [VAR_BITS-1:0]  var_next;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign out_variance = var_reg;

    always_comb
    begin
        num1_next  = NUM_W'(WINDOW) * NUM_W'(in_data.sq_total)
                   - NUM_W'(in_data.sum_total) * NUM_W'(in_data.sum_total);
        prod2_next = PROD_W'(num1_reg) * PROD_W'(RECIP);
        quo3_next  = prod2_reg[RECIP_SHIFT +: QUO_W];
        rem3       = num2_reg - NUM_W'(quo3_next) * NUM_W'(DEN);
        fix3_next  = (rem3 >= NUM_W'(DEN));
        quo_fixed  = {1'b0, quo3_reg} + (QUO_W + 1)'(fix3_reg);
        var_next   = (quo_fixed > (QUO_W + 1)'(VAR_MAX)) ? VAR_BITS'(VAR_MAX)
                                                         : quo_fixed[VAR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num1_reg  <= num1_next;
            num2_reg  <= num1_reg;
            prod2_reg <= prod2_next;
            quo3_reg  <= quo3_next;
            fix3_reg  <= fix3_next;
            var_reg   <= var_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/swv_checker.sv
`default_nettype none

`include "sliding_window_variance_core_macros.svh"

module swv_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [swv_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [swv_pkg::M_DATA_W-1:0]  m_tdata
);
    import swv_pkg::*;

    logic out_stalled;
    logic pad_zero;

    assign out_stalled = m_tvalid && !m_tready;
    assign pad_zero    = ((m_tdata >> VAR_BITS) == '0);

    `SWV_ASSERT_NEXT(a_out_hold, out_stalled, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `SWV_ASSERT_NOW(a_out_pad, m_tvalid, pad_zero, "m_tdata padding not zero")
    `SWV_ASSERT_NOW(a_full_needs_stall, $fell(s_tready), $past(out_stalled), "queue filled without output stall")
    `SWV_ASSERT_NOW(a_full_out_valid, !s_tready, m_tvalid && $past(out_stalled), "input held off without a waiting result")

endmodule

bind sliding_window_variance_core swv_checker u_swv_checker (.*);

`default_nettype wire

>>> tb/sv/sliding_window_variance_core_tb.sv
`timescale 1ns / 100ps

module sliding_window_variance_core_tb;

    import swv_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 100;
    localparam int SETTLE_CYCLES = 16;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   known;
        logic [VAR_BITS-1:0]    variance;
    } dir_row_t;

    // window fills with alternating extremes; typed results are read straight off
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{10'd0,    1'b1, 19'd0},
        '{10'd1023, 1'b1, 19'd43605},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b0, 19'd0},
        '{10'd0,    1'b0, 19'd0},
        '{10'd1023, 1'b1, 19'd273007},
        '{10'd512,  1'b0, 19'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    logic [SAMPLE_BITS-1:0] sample_ring [WINDOW];
    int unsigned            ring_pos;
    longint unsigned        ring_sum;
    longint unsigned        ring_sq_sum;

    logic [VAR_BITS-1:0] variance_due [$];
    logic [VAR_BITS-1:0] due_variance;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks;
    int hold_taken;
    int hold_left;
    int mismatch_cnt;
    int cycle_cnt;

    sliding_window_variance_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [VAR_BITS-1:0] next_variance(input logic [SAMPLE_BITS-1:0] fresh);
        longint unsigned fresh_w;
        longint unsigned stale_w;
        longint unsigned win;
        longint unsigned numer;
        longint unsigned quo;
        fresh_w = fresh;
        stale_w = sample_ring[ring_pos];
        win     = WINDOW;
        sample_ring[ring_pos] = fresh;
        ring_pos    = (ring_pos + 1 == WINDOW) ? 0 : ring_pos + 1;
        ring_sum    = ring_sum + fresh_w - stale_w;
        ring_sq_sum = ring_sq_sum + fresh_w * fresh_w - stale_w * stale_w;
        numer = win * ring_sq_sum - ring_sum * ring_sum;
        quo   = numer / (win * (win - 1));
        if (quo > VAR_MAX)
            quo = VAR_MAX;
        return quo[VAR_BITS-1:0];
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic known,
                               input logic [VAR_BITS-1:0] fixed);
        logic [VAR_BITS-1:0] pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(smp);
        do @(posedge clk); while (!s_tready);
        pred = next_variance(smp);
        variance_due.push_back(known ? fixed : pred);
    endtask

    task automatic send_random(input int count);
        int sent;
        int kind;
        int len;
        int v;
        logic [SAMPLE_BITS-1:0] base;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(4);
            case ($urandom_range(2))
                0: base = '0;
                1: base = '1;
                default: base = SAMPLE_BITS'($urandom_range(1023));
            endcase
            case (kind)
                0: len = $urandom_range(40, 1);
                1: len = $urandom_range(32, 24);
                2: len = $urandom_range(30, 1);
                3: len = $urandom_range(40, 8);
                default: len = $urandom_range(10, 1);
            endcase
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0: v = $urandom_range(1023);
                    1: v = base;
                    2: v = $urandom_range(1) ? 1023 : 0;
                    3:
                    begin
                        v = int'(base) + int'($urandom_range(6)) - 3;
                        if (v < 0)
                            v = 0;
                        if (v > 1023)
                            v = 1023;
                    end
                    default:
                    begin
                        v = 1 << $urandom_range(SAMPLE_BITS - 1);
                        if ($urandom_range(1))
                            v = v ^ 1023;
                    end
                endcase
                send_sample(SAMPLE_BITS'(v), 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (variance_due.size() != 0)
            @(posedge clk);
    endtask

    // hold off, then stall at the set rate
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_taken != hold_asks)
        begin
            hold_taken <= hold_asks;
            hold_left  <= HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (variance_due.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: variance %0d", m_tdata[VAR_BITS-1:0]);
                mismatch_cnt++;
            end
            else
            begin
                due_variance = variance_due.pop_front();
                if (m_tdata[VAR_BITS-1:0] !== due_variance)
                begin
                    if (mismatch_cnt < 10)
                        $display("variance mismatch: expected %0d, got %0d",
                                 due_variance, m_tdata[VAR_BITS-1:0]);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        hold_asks     = 0;
        hold_taken    = 0;
        hold_left     = 0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        ring_pos      = 0;
        ring_sum      = 0;
        ring_sq_sum   = 0;
        send_idle_pct = 26;
        recv_idle_pct = 86;
        for (int i = 0; i < WINDOW; i++)
            sample_ring[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_rows[r].sample, dir_rows[r].known, dir_rows[r].variance);
        send_random(360);

        send_idle_pct = 86;
        recv_idle_pct = 26;
        send_random(370);

        // stall the output while items keep coming, then drain
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks = hold_asks + 1;
        send_random(30);
        wait_drain();

        send_random(365);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/swv_pkg.sv
rtl/core/swv_queue.sv
rtl/core/swv_front.sv
rtl/core/swv_back.sv
rtl/core/sliding_window_variance_core.sv
rtl/core/swv_checker.sv
tb/sv/sliding_window_variance_core_tb.sv
